// File: design/tlrb_pkg.sv
// shared types, codes and defaults for the text line ring buffer
package tlrb_pkg;

  localparam int DEF_MAX_LINES      = 64;
  localparam int DEF_MAX_LINE_CHARS = 128;
  localparam int DEF_MAX_INVERSIONS = 8;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 8;

  localparam logic [6:0] LINE_COUNT_RESET  = 7'd64;
  localparam logic [7:0] LINE_LENGTH_RESET = 8'd80;
  localparam logic [7:0] SPACE_CHAR        = 8'h20;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_LINE_COUNT  = 2'd0,
    CFG_LINE_LENGTH = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_WRITE_CHAR = 2'd0,
    OP_SKIP       = 2'd1,
    OP_BLANK      = 2'd2
  } opcode_t;

  typedef enum logic [1:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] char_code;
    logic       highlight;
  } in_item_t;

  typedef struct packed {
    logic [31:0] newest_line_number;
    logic [5:0]  newest_slot;
    logic [31:0] oldest_line_number;
    logic [5:0]  oldest_slot;
    logic [7:0]  chars_in_line;
    logic [3:0]  inversions_in_line;
    logic        line_start_highlight;
  } out_item_t;

endpackage

// File: design/text_line_ring_buffer_core.sv
// text line ring buffer: line metadata, text and inversion memories with sequencer
//
// usage:
//   input channel (in_valid/in_stall/in_data) takes one beat per command: write a
//   character with its highlight flag, skip to the next line if the current one is
//   nonempty, or start a blank line. every input beat yields exactly one output beat
//   (out_valid/out_stall/out_data) reporting the newest and oldest line pointers and
//   the current line's character count, inversion count and starting highlight.
//   configuration (cfg_valid/cfg_ready/cfg_index/cfg_data) sets line_count and
//   line_length; cfg_ready is always high, writes are meant for idle periods.
// timing:
//   an item is accepted in idle together with the read of the line metadata memory;
//   the next cycle enters execute, which writes the metadata back and registers the
//   result beat once the output register is not held by out_stall. an item that opens a
//   new line adds a sweep over that line's row of the text memory (one column per cycle,
//   single write port), during which no item is accepted.
// reset:
//   synchronous rst; afterwards a clearing pass fills line 0 with spaces and zero
//   metadata before the first item is taken.
// stall:
//   the result sits in the output register while out_stall is high; the block still
//   takes one further item but holds its write-back until the register drains.
module text_line_ring_buffer_core #(
  parameter int MAX_LINES      = tlrb_pkg::DEF_MAX_LINES,
  parameter int MAX_LINE_CHARS = tlrb_pkg::DEF_MAX_LINE_CHARS,
  parameter int MAX_INVERSIONS = tlrb_pkg::DEF_MAX_INVERSIONS
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  tlrb_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output tlrb_pkg::out_item_t             out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tlrb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tlrb_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int IW     = $clog2(MAX_LINES);
  localparam int NW     = $clog2(MAX_LINES + 1);
  localparam int CW     = (MAX_LINE_CHARS > 1) ? $clog2(MAX_LINE_CHARS) : 1;
  localparam int UW     = $clog2(MAX_LINE_CHARS + 1);
  localparam int KW     = (MAX_INVERSIONS > 1) ? $clog2(MAX_INVERSIONS) : 1;
  localparam int VW     = $clog2(MAX_INVERSIONS + 1);
  localparam int TDEPTH = MAX_LINES * MAX_LINE_CHARS;
  localparam int TAW    = $clog2(TDEPTH);
  localparam int VDEPTH = MAX_LINES * MAX_INVERSIONS;
  localparam int VAW    = $clog2(VDEPTH);

  // sequencer and pointers
  tlrb_pkg::state_t state, state_next;
  logic [CW-1:0]    sweep, sweep_next;
  logic [31:0]      newest_number, newest_number_next;
  logic [IW-1:0]    newest_index, newest_index_next;
  logic [31:0]      oldest_number, oldest_number_next;
  logic [IW-1:0]    oldest_index, oldest_index_next;

  // configuration
  logic [6:0] line_count;
  logic [7:0] line_length;

  // accepted item and pending line clear
  tlrb_pkg::in_item_t item;
  logic [IW-1:0]      clr_slot;
  logic               clr_first;
  logic [7:0]         clr_char;

  // memories
  logic [7:0]    text_mem [TDEPTH];
  logic [CW-1:0] inv_mem  [VDEPTH];
  logic [31:0]   num_mem  [MAX_LINES];
  logic          hl_mem   [MAX_LINES];
  logic [UW-1:0] used_mem [MAX_LINES];
  logic [VW-1:0] invc_mem [MAX_LINES];

  // registered metadata read
  logic [31:0]   rd_number;
  logic          rd_hl;
  logic [UW-1:0] rd_used;
  logic [VW-1:0] rd_inv;

  // memory write controls
  logic          text_we;
  logic [TAW-1:0] text_addr;
  logic [7:0]    text_wdata;
  logic          inv_we;
  logic [VAW-1:0] inv_addr;
  logic [CW-1:0] inv_wdata;
  logic          meta_we;
  logic [IW-1:0] meta_addr;
  logic [31:0]   meta_number;
  logic          meta_hl;
  logic [UW-1:0] meta_used;
  logic [VW-1:0] meta_inv;

  // execute datapath
  logic [NW-1:0] eff_lines;
  logic [UW-1:0] eff_len;
  logic [NW-1:0] newest_plus, oldest_plus;
  logic [IW-1:0] adv_index, oldest_adv_index;
  logic [31:0]   adv_number;
  logic          is_write, line_full, adv, exec_go, sweep_end;
  logic          base_hl, new_hl;
  logic [UW-1:0] base_used, new_used;
  logic [VW-1:0] base_inv, new_inv;
  logic [IW-1:0] cur_slot;
  logic [31:0]   cur_number;
  logic          flip_rec;

  // register clamps: line_count to 1..MAX_LINES, line_length to 1..MAX_LINE_CHARS
  always_comb begin
    if (line_count == '0) begin
      eff_lines = NW'(1);
    end else if (32'(line_count) > 32'(MAX_LINES)) begin
      eff_lines = NW'(MAX_LINES);
    end else begin
      eff_lines = NW'(line_count);
    end
    if (line_length == '0) begin
      eff_len = UW'(1);
    end else if (32'(line_length) > 32'(MAX_LINE_CHARS)) begin
      eff_len = UW'(MAX_LINE_CHARS);
    end else begin
      eff_len = UW'(line_length);
    end
  end

  // item datapath, valid in ST_EXEC on the registered metadata
  always_comb begin
    is_write  = (item.opcode == tlrb_pkg::OP_WRITE_CHAR);
    line_full = (rd_used >= eff_len);
    adv       = (is_write && line_full) ||
                (item.opcode == tlrb_pkg::OP_SKIP && rd_used != '0) ||
                (item.opcode == tlrb_pkg::OP_BLANK);

    newest_plus = NW'(newest_index) + NW'(1);
    adv_index   = (newest_plus >= eff_lines) ? '0 : IW'(newest_plus);
    adv_number  = newest_number + 32'd1;
    oldest_plus = NW'(oldest_index) + NW'(1);
    oldest_adv_index = (oldest_plus >= eff_lines) ? '0 : IW'(oldest_plus);

    // a fresh line starts empty, unhighlighted, without inversions
    cur_slot   = adv ? adv_index : newest_index;
    cur_number = adv ? adv_number : rd_number;
    base_hl    = adv ? 1'b0 : rd_hl;
    base_used  = adv ? '0 : rd_used;
    base_inv   = adv ? '0 : rd_inv;

    new_hl   = base_hl;
    new_used = base_used;
    new_inv  = base_inv;
    flip_rec = 1'b0;
    if (is_write) begin
      if (base_used == '0) begin
        new_hl = item.highlight;
      end else if ((base_hl ^ base_inv[0]) != item.highlight &&
                   32'(base_inv) < 32'(MAX_INVERSIONS)) begin
        flip_rec = 1'b1;
        new_inv  = base_inv + VW'(1);
      end
      new_used = base_used + UW'(1);
    end
  end

  assign sweep_end = (sweep == CW'(MAX_LINE_CHARS - 1));
  assign exec_go   = (state == tlrb_pkg::ST_EXEC) && !(out_valid && out_stall);
  assign cfg_ready = 1'b1;

  // sequencer: next state and memory write controls
  always_comb begin
    state_next         = state;
    sweep_next         = sweep;
    newest_number_next = newest_number;
    newest_index_next  = newest_index;
    oldest_number_next = oldest_number;
    oldest_index_next  = oldest_index;
    in_stall           = 1'b1;
    text_we            = 1'b0;
    text_addr          = TAW'(newest_index) * TAW'(MAX_LINE_CHARS) + TAW'(rd_used);
    text_wdata         = item.char_code;
    inv_we             = 1'b0;
    inv_addr           = VAW'(cur_slot) * VAW'(MAX_INVERSIONS) + VAW'(base_inv);
    inv_wdata          = CW'(base_used);
    meta_we            = 1'b0;
    meta_addr          = cur_slot;
    meta_number        = cur_number;
    meta_hl            = new_hl;
    meta_used          = new_used;
    meta_inv           = new_inv;

    unique case (state)
      tlrb_pkg::ST_INIT, tlrb_pkg::ST_CLEAR: begin
        // one column a cycle: spaces (column 0 may take the new char), inversion slots to zero
        text_we    = 1'b1;
        text_addr  = TAW'(clr_slot) * TAW'(MAX_LINE_CHARS) + TAW'(sweep);
        text_wdata = (sweep == '0 && clr_first) ? clr_char : tlrb_pkg::SPACE_CHAR;
        inv_we     = (32'(sweep) < 32'(MAX_INVERSIONS));
        inv_addr   = VAW'(clr_slot) * VAW'(MAX_INVERSIONS) + VAW'(KW'(sweep));
        inv_wdata  = '0;
        // line 0 metadata after reset
        meta_we     = (state == tlrb_pkg::ST_INIT) && (sweep == '0);
        meta_addr   = '0;
        meta_number = '0;
        meta_hl     = 1'b0;
        meta_used   = '0;
        meta_inv    = '0;
        if (sweep_end) begin
          sweep_next = '0;
          state_next = tlrb_pkg::ST_IDLE;
        end else begin
          sweep_next = sweep + CW'(1);
        end
      end
      tlrb_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = tlrb_pkg::ST_EXEC;
        end
      end
      tlrb_pkg::ST_EXEC: begin
        if (exec_go) begin
          meta_we = 1'b1;
          inv_we  = flip_rec;
          // a character for a fresh line is written by the clear sweep
          text_we = is_write && !adv && (32'(rd_used) < 32'(MAX_LINE_CHARS));
          if (adv) begin
            newest_number_next = adv_number;
            newest_index_next  = adv_index;
            if (adv_number >= 32'(eff_lines)) begin
              oldest_number_next = oldest_number + 32'd1;
              oldest_index_next  = oldest_adv_index;
            end
            state_next = tlrb_pkg::ST_CLEAR;
          end else begin
            state_next = tlrb_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = tlrb_pkg::ST_INIT;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= tlrb_pkg::ST_INIT;
      sweep         <= '0;
      newest_number <= '0;
      newest_index  <= '0;
      oldest_number <= '0;
      oldest_index  <= '0;
      line_count    <= tlrb_pkg::LINE_COUNT_RESET;
      line_length   <= tlrb_pkg::LINE_LENGTH_RESET;
      out_valid     <= 1'b0;
      clr_slot      <= '0;
      clr_first     <= 1'b0;
    end else begin
      state         <= state_next;
      sweep         <= sweep_next;
      newest_number <= newest_number_next;
      newest_index  <= newest_index_next;
      oldest_number <= oldest_number_next;
      oldest_index  <= oldest_index_next;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          tlrb_pkg::CFG_LINE_COUNT:  line_count  <= cfg_data[6:0];
          tlrb_pkg::CFG_LINE_LENGTH: line_length <= cfg_data;
          default: ;
        endcase
      end
      if (exec_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (exec_go && adv) begin
        clr_slot  <= adv_index;
        clr_first <= is_write;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == tlrb_pkg::ST_IDLE && in_valid) begin
      item <= in_data;
    end
    if (exec_go) begin
      clr_char <= item.char_code;
      out_data.newest_line_number   <= cur_number;
      out_data.newest_slot          <= 6'(cur_slot);
      out_data.oldest_line_number   <= oldest_number_next;
      out_data.oldest_slot          <= 6'(oldest_index_next);
      out_data.chars_in_line        <= 8'(new_used);
      out_data.inversions_in_line   <= 4'(new_inv);
      out_data.line_start_highlight <= new_hl;
    end
  end

  // line metadata memory: read at acceptance, written back in execute, zeroed for line 0 after reset
  always_ff @(posedge clk) begin
    if (meta_we) begin
      num_mem[meta_addr]  <= meta_number;
      hl_mem[meta_addr]   <= meta_hl;
      used_mem[meta_addr] <= meta_used;
      invc_mem[meta_addr] <= meta_inv;
    end
    if (state == tlrb_pkg::ST_IDLE && in_valid) begin
      rd_number <= num_mem[newest_index];
      rd_hl     <= hl_mem[newest_index];
      rd_used   <= used_mem[newest_index];
      rd_inv    <= invc_mem[newest_index];
    end
  end

  // text memory
  always_ff @(posedge clk) begin
    if (text_we) begin
      text_mem[text_addr] <= text_wdata;
    end
  end

  // inversion position memory
  always_ff @(posedge clk) begin
    if (inv_we) begin
      inv_mem[inv_addr] <= inv_wdata;
    end
  end

  // an accepted beat always goes to execute
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> state == tlrb_pkg::ST_EXEC)
    else $error("accepted beat did not enter execute");

  // a new result appears only out of execute
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == tlrb_pkg::ST_EXEC)
    else $error("result beat without an executed item");

  // metadata is never written while waiting for an item
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    state == tlrb_pkg::ST_IDLE |-> !meta_we && !text_we && !inv_we)
    else $error("memory write while idle");

  // opening a new line always runs the clear sweep
  a_adv_clear: assert property (@(posedge clk) disable iff (rst)
    exec_go && adv |=> state == tlrb_pkg::ST_CLEAR && sweep == '0)
    else $error("new line without clear sweep");

endmodule
